### src/lpcm_pack_timestamp_gen_macros.svh
// Assertion macros shared by the timestamp generator RTL.
`ifndef LPCM_PACK_TIMESTAMP_GEN_MACROS_SVH
`define LPCM_PACK_TIMESTAMP_GEN_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define LPTS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define LPTS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LPTS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define LPTS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

### src/lpts_pkg.sv
// Shared types, constants and helpers of the LPCM pack timestamp generator.
`default_nettype none
package lpts_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Clock rates and fixed offsets.
  localparam logic [24:0] SCR_CLOCK  = 25'd27000000;
  localparam logic [16:0] PTS_CLOCK  = 17'd90000;
  localparam logic [31:0] PTS_START  = 32'd585;
  localparam logic [21:0] OFFSET_C   = 22'd2808217;   // 42.85 with 16 fraction bits
  localparam logic [8:0]  EXT_DIV    = 9'd300;
  localparam logic [58:0] SCR_MOD    = 59'd300 << 49; // 300 * 2^49

  // Steps of the iterative divider for the derived SCR terms.
  localparam int unsigned DIV_STEPS  = 57;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAYLOAD   = 3'd0,
    REG_SHORTFALL = 3'd1,
    REG_FRAME     = 3'd2,
    REG_RATE      = 3'd3,
    REG_OFFSET    = 3'd4
  } reg_idx_t;

  // Sequencer states of the derived-term divider.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PAY,
    ST_OFF
  } cfg_state_t;

  // Configuration and derived terms handed to the datapath.
  typedef struct packed {
    logic [11:0] payload_bytes;
    logic [11:0] first_pack_shortfall;
    logic [15:0] frame_bytes;
    logic [23:0] byte_rate;
    logic [52:0] pay_term;  // payload_bytes*27e6*2^16/byte_rate
    logic [58:0] off_sum;   // offset term + 300*2^49 - 42.85
    logic        busy;
  } cfg_t;

  // Ramp term of the first packs: k*307200/7 with 16 fraction bits, truncated.
  function automatic logic [33:0] ramp_fx(input logic [2:0] k);
    logic [33:0] r;
    r = '0;
    case (k)
      3'd1:    r = 34'd2876094171;
      3'd2:    r = 34'd5752188342;
      3'd3:    r = 34'd8628282514;
      3'd4:    r = 34'd11504376685;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### src/lpts_cfg.sv
// Configuration registers and the sequential divider for derived SCR terms.
`default_nettype none
`include "lpcm_pack_timestamp_gen_macros.svh"
module lpts_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          we,
  input  logic [lpts_pkg::CFG_IDX_W-1:0]  index,
  input  logic [lpts_pkg::CFG_DATA_W-1:0] data,
  output lpts_pkg::cfg_t                cfg
);
  import lpts_pkg::*;

  localparam logic [5:0] LAST_STEP = 6'(DIV_STEPS - 1);

  logic [11:0] payload_bytes;
  logic [11:0] first_pack_shortfall;
  logic [15:0] frame_bytes;
  logic [23:0] byte_rate;
  logic [15:0] scr_offset_bytes;

  cfg_state_t  state, state_next;
  logic [5:0]  step, step_next;
  logic [23:0] rem, rem_next;
  logic [56:0] num, num_next;
  logic [52:0] pay_term, pay_term_next;
  logic [58:0] off_sum, off_sum_next;

  logic [36:0] pay_prod;
  logic [40:0] off_prod;
  logic [24:0] r2;
  logic [24:0] r2_diff;
  logic        ge;
  logic [23:0] rem_step;
  logic [56:0] num_step;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_bytes        <= 12'd2000;
      first_pack_shortfall <= 12'd16;
      frame_bytes          <= 16'd160;
      byte_rate            <= 24'd192000;
      scr_offset_bytes     <= 16'd0;
    end else if (we) begin
      case (reg_idx_t'(index))
        REG_PAYLOAD:   payload_bytes        <= data[11:0];
        REG_SHORTFALL: first_pack_shortfall <= data[11:0];
        REG_FRAME:     frame_bytes          <= data[15:0];
        REG_RATE:      byte_rate            <= data;
        REG_OFFSET:    scr_offset_bytes     <= data[15:0];
        default: ;
      endcase
    end
  end

  // Numerators of the two derived terms; the 2^16 scaling is applied at load.
  assign pay_prod = 37'(payload_bytes) * 37'(SCR_CLOCK);
  assign off_prod = 41'(scr_offset_bytes) * 41'(SCR_CLOCK);

  // One restoring division step: shift in a dividend bit, compare and subtract.
  assign r2       = {rem, num[56]};
  assign r2_diff  = r2 - {1'b0, byte_rate};
  assign ge       = (r2 >= {1'b0, byte_rate});
  assign rem_step = ge ? r2_diff[23:0] : r2[23:0];
  assign num_step = {num[55:0], ge};

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    rem      <= rem_next;
    num      <= num_next;
    pay_term <= pay_term_next;
    off_sum  <= off_sum_next;
  end

  // Next state: payload term first, then the offset term; a write restarts the sequence.
  always_comb begin
    state_next    = state;
    step_next     = step;
    rem_next      = rem;
    num_next      = num;
    pay_term_next = pay_term;
    off_sum_next  = off_sum;
    unique case (state)
      ST_IDLE: ;
      ST_LOAD: begin
        rem_next   = '0;
        num_next   = {4'b0, pay_prod, 16'b0};
        step_next  = '0;
        state_next = ST_PAY;
      end
      ST_PAY: begin
        rem_next  = rem_step;
        num_next  = num_step;
        step_next = step + 6'd1;
        if (step == LAST_STEP) begin
          pay_term_next = num_step[52:0];
          rem_next      = '0;
          num_next      = {off_prod, 16'b0};
          step_next     = '0;
          state_next    = ST_OFF;
        end
      end
      ST_OFF: begin
        rem_next  = rem_step;
        num_next  = num_step;
        step_next = step + 6'd1;
        if (step == LAST_STEP) begin
          off_sum_next = {2'b0, num_step} + SCR_MOD - 59'(OFFSET_C);
          step_next    = '0;
          state_next   = ST_IDLE;
        end
      end
    endcase
    if (we) begin
      state_next = ST_LOAD;
    end
  end

  assign cfg.payload_bytes        = payload_bytes;
  assign cfg.first_pack_shortfall = first_pack_shortfall;
  assign cfg.frame_bytes          = frame_bytes;
  assign cfg.byte_rate            = byte_rate;
  assign cfg.pay_term             = pay_term;
  assign cfg.off_sum              = off_sum;
  assign cfg.busy                 = (state != ST_IDLE);

  `LPTS_ASSERT_NXT(a_write_restarts, clk, rst, we, state == ST_LOAD, "write did not restart")
  `LPTS_ASSERT_IMP(a_terms_hold, clk, rst, !cfg.busy && !$past(cfg.busy), $stable(pay_term) && $stable(off_sum), "derived terms moved while idle")
  `LPTS_ASSERT_IMP(a_step_range, clk, rst, state == ST_PAY || state == ST_OFF, step <= LAST_STEP, "step count overrun")

endmodule
`default_nettype wire

### src/lpts_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none
`include "lpcm_pack_timestamp_gen_macros.svh"
module lpts_div_pipe #(
  parameter int unsigned NW = 44,  // dividend width, also the stage count
  parameter int unsigned DW = 16,  // divisor width
  parameter int unsigned QW = 32,  // low quotient bits kept, 2 to NW
  parameter int unsigned SW = 1    // side data carried along
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_v,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] d,
  input  logic [SW-1:0] in_side,
  output logic          out_v,
  output logic [QW-1:0] out_quo,
  output logic [DW-1:0] out_rem,
  output logic [SW-1:0] out_side
);
  import lpts_pkg::*;

  logic [NW:0]   v;
  logic [DW-1:0] rem  [NW+1];
  logic [NW-1:0] num  [NW+1];
  logic [QW-1:0] quo  [NW+1];
  logic [SW-1:0] side [NW+1];

  assign v[0]    = in_v;
  assign rem[0]  = '0;
  assign num[0]  = in_num;
  assign quo[0]  = '0;
  assign side[0] = in_side;

  // Each stage brings down one dividend bit and decides one quotient bit.
  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW:0] r2;
    logic [DW:0] diff;
    logic        ge;

    assign r2   = {rem[s], num[s][NW-1]};
    assign diff = r2 - {1'b0, d};
    assign ge   = (r2 >= {1'b0, d});

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (en) begin
        v[s+1] <= v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1]  <= ge ? diff[DW-1:0] : r2[DW-1:0];
        num[s+1]  <= {num[s][NW-2:0], 1'b0};
        quo[s+1]  <= {quo[s][QW-2:0], ge};
        side[s+1] <= side[s];
      end
    end
  end

  assign out_v    = v[NW];
  assign out_quo  = quo[NW];
  assign out_rem  = rem[NW];
  assign out_side = side[NW];

  `LPTS_ASSERT_IMP(a_rem_below_div, clk, rst, out_v && (d != '0), out_rem < d, "remainder not below divisor")
  `LPTS_ASSERT_NXT(a_hold_on_stall, clk, rst, !en, $stable(out_v) && $stable(out_rem), "divider moved while held")

endmodule
`default_nettype wire

### src/lpcm_pack_timestamp_gen.sv
// Top level: SCR and PTS computation and header field packing for LPCM packs.
//
//  channel   signals                         direction  role
//  pack      pack_valid/pack_stall, index    in         one pack index per beat
//  ts        ts_valid/ts_stall, 6 fields     out        one timestamp set per beat
//  cfg       cfg_we, cfg_index, cfg_data     in         register writes
//
// One beat enters per cycle unless pack is stalled by the register rebuild or by ts.
// The depth is set by two bit-per-stage dividers of 44 and 62 stages and by an
// eight-stage radix-65536 divide by 300 that splits the SCR.
// After reset and after every register write the block stalls pack beats
// while the iterative divider rebuilds the derived SCR terms.
// A stall on ts while ts_valid is high freezes the whole pipeline; pack_stall follows it in the same cycle.
`default_nettype none
`include "lpcm_pack_timestamp_gen_macros.svh"
module lpcm_pack_timestamp_gen (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lpts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpts_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            pack_valid,
  output logic                            pack_stall,
  input  logic [31:0]                     pack_index,
  output logic                            ts_valid,
  input  logic                            ts_stall,
  output logic [32:0]                     scr_main,
  output logic [8:0]                      scr_extension,
  output logic [47:0]                     scr_field,
  output logic [31:0]                     pts_value,
  output logic [39:0]                     pts_field,
  output logic                            rate_zero
);
  import lpts_pkg::*;

  cfg_t cfg;
  logic en;

  lpts_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  // The whole pipeline advances unless a finished result is held.
  assign en         = !ts_valid || !ts_stall;
  assign pack_stall = cfg.busy || !en;

  // Stage 1: capture the pack index.
  logic        s1_v;
  logic [31:0] s1_p;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= pack_valid && !cfg.busy;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_p <= pack_index;
    end
  end

  // Stage 2: bytes before shortfall, ramp term and payload multiplier.
  logic        s2_v, s2_p4, s2_pz;
  logic [43:0] s2_prodb;
  logic [31:0] s2_q;
  logic [33:0] s2_ramp;
  logic [2:0]  s1_k;
  assign s1_k = (s1_p < 32'd4) ? s1_p[2:0] : 3'd4;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_prodb <= 44'(s1_p) * 44'(cfg.payload_bytes);
      s2_q     <= (s1_p >= 32'd5) ? s1_p - 32'd4 : 32'd0;
      s2_ramp  <= ramp_fx(s1_k);
      s2_p4    <= (s1_p >= 32'd4);
      s2_pz    <= (s1_p == 32'd0);
    end
  end

  // Stage 3: saturating shortfall, the two partial products of the payload term and the base term.
  logic        s3_v, s3_pz;
  logic [43:0] s3_bw;
  logic [58:0] s3_m0;
  logic [57:0] s3_m1;
  logic [59:0] s3_base;
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_bw   <= (s2_prodb > 44'(cfg.first_pack_shortfall)) ?
                 s2_prodb - 44'(cfg.first_pack_shortfall) : 44'd0;
      s3_m0   <= 59'(s2_q) * 59'(cfg.pay_term[26:0]);
      s3_m1   <= 58'(s2_q) * 58'(cfg.pay_term[52:27]);
      s3_base <= 60'(s2_ramp) + (s2_p4 ? 60'(cfg.off_sum) : 60'd0);
      s3_pz   <= s2_pz;
    end
  end

  // Stage 4: full SCR sum in 16-fraction-bit fixed point.
  logic        s4_v, s4_pz;
  logic [43:0] s4_bw;
  logic [85:0] s4_s;
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= s3_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_s  <= 86'(s3_m0) + (86'(s3_m1) << 27) + 86'(s3_base);
      s4_bw <= s3_bw;
      s4_pz <= s3_pz;
    end
  end

  // Bytes written modulo the frame size.
  localparam int unsigned A_SW = 1 + 44 + 86;
  logic            a_v;
  logic [15:0]     a_rem;
  logic [A_SW-1:0] a_side;
  lpts_div_pipe #(.NW(44), .DW(16), .QW(2), .SW(A_SW)) u_div_frame (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (s4_v),
    .in_num   (s4_bw),
    .d        (cfg.frame_bytes),
    .in_side  ({s4_pz, s4_bw, s4_s}),
    .out_v    (a_v),
    .out_quo  (),
    .out_rem  (a_rem),
    .out_side (a_side)
  );

  // Stage 5: round bytes written up to whole frames.
  logic        s5_v, s5_pz;
  logic [44:0] s5_bwr;
  logic [85:0] s5_s;
  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (en) begin
      s5_v <= a_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if ((cfg.frame_bytes != 16'd0) && (a_rem != 16'd0)) begin
        s5_bwr <= 45'(a_side[129:86]) + 45'(cfg.frame_bytes) - 45'(a_rem);
      end else begin
        s5_bwr <= 45'(a_side[129:86]);
      end
      s5_pz <= a_side[130];
      s5_s  <= a_side[85:0];
    end
  end

  // Stage 6: scale to 90 kHz ticks.
  logic        s6_v, s6_pz;
  logic [61:0] s6_n;
  logic [85:0] s6_s;
  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (en) begin
      s6_v <= s5_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s6_n  <= 62'(s5_bwr) * 62'(PTS_CLOCK);
      s6_pz <= s5_pz;
      s6_s  <= s5_s;
    end
  end

  // PTS ticks divided by the byte rate.
  localparam int unsigned B_SW = 1 + 86;
  logic            b_v;
  logic [31:0]     b_quo;
  logic [B_SW-1:0] b_side;
  lpts_div_pipe #(.NW(62), .DW(24), .QW(32), .SW(B_SW)) u_div_pts (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (s6_v),
    .in_num   (s6_n),
    .d        (cfg.byte_rate),
    .in_side  ({s6_pz, s6_s}),
    .out_v    (b_v),
    .out_quo  (b_quo),
    .out_rem  (),
    .out_side (b_side)
  );

  // Stage 7: PTS start offset; pack 0 gets the start offset alone.
  logic        s7_v;
  logic [31:0] s7_pts;
  logic [85:0] s7_s;
  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
    end else if (en) begin
      s7_v <= b_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s7_pts <= b_side[86] ? PTS_START : b_quo + PTS_START;
      s7_s   <= b_side[85:0];
    end
  end

  // Integer SCR (sum without its fraction bits) divided by 300, one 16-bit digit
  // per two stages. The top six bits start the remainder; the quotient digit comes
  // from a reciprocal product that is exact for any value below 300*2^16.
  localparam logic [25:0] RCP_300 = 26'd57266231;  // ceil(2^34 / 300)
  logic        e_v   [5];
  logic [8:0]  e_rem [5];
  logic [63:0] e_dig [5];
  logic [32:0] e_quo [5];
  logic [31:0] e_pts [5];

  assign e_v[0]   = s7_v;
  assign e_rem[0] = 9'(s7_s[85:80]);
  assign e_dig[0] = s7_s[79:16];
  assign e_quo[0] = '0;
  assign e_pts[0] = s7_pts;

  for (genvar g = 0; g < 4; g++) begin : g_ext
    logic        a_v;
    logic [24:0] a_val;
    logic [16:0] a_q;
    logic [47:0] a_dig;
    logic [32:0] a_quo;
    logic [31:0] a_pts;
    logic [24:0] val;
    logic [50:0] prod;
    logic [24:0] diff;

    assign val  = {e_rem[g], e_dig[g][63:48]};
    assign prod = 51'(val) * 51'(RCP_300);
    assign diff = a_val - 25'(a_q) * 25'(EXT_DIV);

    // First stage: quotient digit from the reciprocal product.
    always_ff @(posedge clk) begin
      if (rst) begin
        a_v <= 1'b0;
      end else if (en) begin
        a_v <= e_v[g];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        a_val <= val;
        a_q   <= prod[50:34];
        a_dig <= e_dig[g][47:0];
        a_quo <= e_quo[g];
        a_pts <= e_pts[g];
      end
    end

    // Second stage: new remainder, and the digit joins the quotient.
    always_ff @(posedge clk) begin
      if (rst) begin
        e_v[g+1] <= 1'b0;
      end else if (en) begin
        e_v[g+1] <= a_v;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        e_rem[g+1] <= diff[8:0];
        e_dig[g+1] <= {a_dig, 16'b0};
        e_quo[g+1] <= {a_quo[16:0], a_q[15:0]};
        e_pts[g+1] <= a_pts;
      end
    end
  end

  // Output register: header packing and the zero-rate override.
  logic rz;
  assign rz = (cfg.byte_rate == 24'd0);
  always_ff @(posedge clk) begin
    if (rst) begin
      ts_valid <= 1'b0;
    end else if (en) begin
      ts_valid <= e_v[4];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rate_zero <= rz;
      if (rz) begin
        scr_main      <= '0;
        scr_extension <= '0;
        scr_field     <= '0;
        pts_value     <= '0;
        pts_field     <= '0;
      end else begin
        scr_main      <= e_quo[4];
        scr_extension <= e_rem[4];
        scr_field     <= {2'b01, e_quo[4][32:30], 1'b1, e_quo[4][29:15], 1'b1,
                          e_quo[4][14:0], 1'b1, e_rem[4], 1'b1};
        pts_value     <= e_pts[4];
        pts_field     <= {4'b0010, 1'b0, e_pts[4][31:30], 1'b1, e_pts[4][29:15], 1'b1,
                          e_pts[4][14:0], 1'b1};
      end
    end
  end

  `LPTS_ASSERT_IMP(a_zero_rate, clk, rst, ts_valid && rate_zero, scr_main == 33'd0 && pts_value == 32'd0 && scr_field == 48'd0, "zero rate result not cleared")
  `LPTS_ASSERT_IMP(a_ext_range, clk, rst, ts_valid && !rate_zero, scr_extension < EXT_DIV, "SCR extension out of range")
  `LPTS_ASSERT_NXT(a_busy_blocks, clk, rst, cfg.busy && en, !s1_v, "beat entered while terms rebuilt")

endmodule
`default_nettype wire
